// ----- hdl/float_fixed_converter_assert.svh -----
// Assertion macros for the float/fixed converter checker.
`ifndef FLOAT_FIXED_CONVERTER_ASSERT_SVH
`define FLOAT_FIXED_CONVERTER_ASSERT_SVH
// Implication checked on every clock, skipped while in reset.
`define FFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define FFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hdl/ffc_pkg.sv -----
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types and constants for the float/fixed converter.
// ----------------------------------------------------------------------------
`default_nettype none
package ffc_pkg;
    localparam int ExpBias = 127;
    localparam int Q16Drop = 11;

    typedef enum logic {OP_F2X = 1'b0, OP_X2F = 1'b1} op_t;
    typedef enum logic {FMT_Q8_23 = 1'b0, FMT_Q3_12 = 1'b1} fmt_t;
    // Register index, taken from paddr[2] (one 32-bit register per 4 bytes).
    localparam logic REG_FORMAT = 1'b0;

    typedef struct packed {
        logic        op;
        logic        fmt;
        logic [31:0] value;
    } ffc_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        overflow;
    } ffc_result_t;
endpackage
`default_nettype wire

// ----- hdl/ffc_f2x.sv -----
// ----------------------------------------------------------------------------
// ffc_f2x
// Float32 bits to Q8.23 (round to nearest even) or Q3.12 (truncated) code.
// ----------------------------------------------------------------------------
`default_nettype none
module ffc_f2x
    import ffc_pkg::*;
(
    input  wire logic [31:0] bits,
    input  wire logic        fmt,
    output logic      [31:0] code,
    output logic             overflow
);
    logic        sgn;
    logic [7:0]  ex;
    logic [23:0] m;
    logic [7:0]  sh;
    logic [54:0] wide;
    logic [23:0] rem;
    logic [23:0] half;
    logic [30:0] q;
    logic [31:0] mag;
    logic        rnd;
    logic [31:0] c;

    always_comb
    begin
        sgn  = bits[31];
        ex   = bits[30:23];
        m    = {(ex != 8'd0), bits[22:0]};
        code = '0;
        overflow = 1'b0;
        mag  = '0;
        sh   = '0;
        wide = '0;
        rem  = '0;
        half = '0;
        q    = '0;
        rnd  = 1'b0;
        c    = '0;
        if (ex == 8'hFF) begin
            overflow = 1'b1;
        end else if (ex >= 8'd158) begin
            overflow = 1'b1;
        end else begin
            if (ex >= 8'd127) begin
                wide = {31'd0, m} << (ex - 8'd127);
                mag  = wide[31:0];
            end else begin
                // right shift by (127 - e'), with e'=1 for subnormals
                sh = (ex == 8'd0) ? 8'd126 : (8'd127 - ex);
                if (sh > 8'd24) begin
                    mag = '0;
                end else begin
                    q    = 31'({m} >> sh);
                    rem  = m & ((24'd1 << sh) - 24'd1);
                    half = 24'd1 << (sh - 8'd1);
                    rnd  = (rem > half) || ((rem == half) && q[0]);
                    mag  = {1'b0, q} + {31'd0, rnd};
                end
            end
            // bits of the shifted magnitude above 31 also count as overflow
            if (fmt == FMT_Q8_23) begin
                overflow = (mag[31] != 1'b0) || (wide[54:32] != 23'd0);
                c = {1'b0, mag[30:0]};
                if (sgn)
                    c = 32'd0 - c;
            end else begin
                overflow = (mag[31:26] != 6'd0) || (wide[54:32] != 23'd0);
                c = {16'd0, 1'b0, mag[25:11]};
                if (sgn)
                    c = {16'd0, 16'(16'd0 - c[15:0])};
            end
            code = c;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/ffc_x2f.sv -----
// ----------------------------------------------------------------------------
// ffc_x2f
// Q8.23 or Q3.12 fixed code to float32 bit pattern, round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none
module ffc_x2f
    import ffc_pkg::*;
(
    input  wire logic [31:0] v,
    input  wire logic        fmt,
    output logic      [31:0] bits
);
    logic        sgn;
    logic [31:0] mag;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [24:0] mant;
    logic        g;
    logic        st;
    logic [7:0]  bexp;

    always_comb
    begin
        if (fmt == FMT_Q8_23) begin
            sgn = v[31];
            mag = sgn ? (32'd0 - v) : v;
        end else begin
            sgn = v[15];
            mag = {16'd0, (sgn ? 16'(16'd0 - v[15:0]) : v[15:0])};
            if (sgn && mag == 32'd0)
                mag = 32'h8000;
        end
        p = '0;
        for (int i = 0; i < 32; i++)
            if (mag[i])
                p = 5'(i);
        norm = mag << (5'd31 - p);
        g    = norm[7];
        st   = (norm[6:0] != 7'd0);
        mant = {1'b0, norm[31:8]} + {24'd0, g && (st || norm[8])};
        bexp = 8'({3'd0, p}) + 8'(ExpBias) - ((fmt == FMT_Q8_23) ? 8'd23 : 8'd12);
        if (mant[24]) begin
            bexp = bexp + 8'd1;
            mant = mant >> 1;
        end
        bits = (mag == 32'd0) ? 32'd0 : {sgn, bexp, mant[22:0]};
    end
endmodule
`default_nettype wire

// ----- hdl/float_fixed_converter.sv -----
// Each accepted word passes the input register, conversion, result register.
// Throughput: one word per cycle while m_tready is high; s_tready is passed
// straight back from m_tready when both registers hold a word.
// Reset: rst_n asynchronous low; clears valids and sets fmt_reg to 0.
`default_nettype none
// ----------------------------------------------------------------------------
// float_fixed_converter
// Stream converter between float32 and Q8.23/Q3.12 fixed point.
// ----------------------------------------------------------------------------
module float_fixed_converter
    import ffc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value_in[31:0]
    input  wire logic        s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // value_out[31:0]
    output logic             m_tuser,   // overflow
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    logic        fmt_reg;
    ffc_item_t   item_reg;
    logic        item_v_reg;
    ffc_result_t res_reg;
    logic        res_v_reg;
    logic [31:0] f2x_code;
    logic        f2x_ovf;
    logic [31:0] x2f_bits;
    logic        adv;

    assign pready = 1'b1;
    assign prdata = {31'd0, fmt_reg};

    // Hold the format register; written by a completed APB write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr[2] == REG_FORMAT)
            fmt_reg <= pwdata[0];
    end

    // Advance the input stage when the result register is free or draining.
    assign adv      = !res_v_reg || m_tready;
    assign s_tready = !item_v_reg || adv;

    ffc_f2x u_f2x (.bits(item_reg.value), .fmt(item_reg.fmt),
                   .code(f2x_code), .overflow(f2x_ovf));
    ffc_x2f u_x2f (.v(item_reg.value), .fmt(item_reg.fmt), .bits(x2f_bits));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_v_reg <= 1'b0;
            res_v_reg  <= 1'b0;
        end else begin
            if (s_tready)
                item_v_reg <= s_tvalid;
            if (adv)
                res_v_reg <= item_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            item_reg <= '{op: s_tuser, fmt: fmt_reg, value: s_tdata};
        if (adv && item_v_reg) begin
            if (item_reg.op == OP_F2X)
                res_reg <= '{value: f2x_code, overflow: f2x_ovf};
            else
                res_reg <= '{value: x2f_bits, overflow: 1'b0};
        end
    end

    assign m_tvalid = res_v_reg;
    assign m_tdata  = res_reg.value;
    assign m_tuser  = res_reg.overflow;
endmodule
`default_nettype wire

// ----- hdl/ffc_checker.sv -----
// ----------------------------------------------------------------------------
// ffc_assert
// Port-level checks for the float/fixed converter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "float_fixed_converter_assert.svh"
module ffc_assert (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        pready
);
    `FFC_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `FFC_ASSERT_IMP(a_rdy, clk, rst_n, !m_tvalid, s_tready)
    `FFC_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)
    `FFC_ASSERT_IMP(a_known, clk, rst_n, m_tvalid, !$isunknown(m_tdata) && !$isunknown(m_tuser))
endmodule
bind float_fixed_converter ffc_assert u_ffc_assert (.*);
`default_nettype wire

// ----- bench/ffc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffc_checker
// Watches the converter's input, output and register ports, predicts each
// result word and compares it with what the block returns.
// ----------------------------------------------------------------------------
module ffc_checker
    import ffc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pending
);
    fmt_t          cur_fmt;
    ffc_result_t   expected_words[$];

    // Round a magnitude right by sh bits, ties to even.
    function automatic logic [63:0] round_shift(logic [63:0] m, int sh);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (sh == 0)
            return m;
        if (sh > 40)
            return 64'd0;
        q    = m >> sh;
        rem  = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        return q;
    endfunction

    function automatic ffc_result_t to_fixed(logic [31:0] bits, fmt_t f);
        ffc_result_t r;
        logic [7:0]  ex;
        logic [63:0] m;
        logic [63:0] mag;
        logic [63:0] ip;
        logic [63:0] code;
        logic [63:0] mask;
        int          e;
        ex = bits[30:23];
        m  = {41'd0, bits[22:0]};
        r  = '0;
        if (ex == 8'hFF)
        begin
            r.overflow = 1'b1;
            return r;
        end
        if (ex == 8'd0)
            e = 1 - 127;
        else
        begin
            e = int'(ex) - 127;
            m[23] = 1'b1;
        end
        if (e >= 31)
        begin
            r.overflow = (m != 0);
            return r;
        end
        mag = (e >= 0) ? (m << e) : round_shift(m, -e);
        ip  = mag >> 23;
        if (f == FMT_Q8_23)
        begin
            r.overflow = ip > 255;
            code = ((ip & 64'hFF) << 23) | (mag & 64'h7FFFFF);
            mask = 64'hFFFF_FFFF;
        end
        else
        begin
            r.overflow = ip > 7;
            code = ((ip & 64'h7) << 12) | ((mag & 64'h7FFFFF) >> 11);
            mask = 64'hFFFF;
        end
        if (bits[31])
            code = (64'd0 - code) & mask;
        r.value = code[31:0] & mask[31:0];
        return r;
    endfunction

    function automatic logic [31:0] to_float(logic [31:0] v, fmt_t f);
        logic        sgn;
        logic [31:0] mag;
        logic [63:0] mant;
        logic [31:0] bexp;
        int          p;
        int          fb;
        if (f == FMT_Q8_23)
        begin
            sgn = v[31];
            fb  = 23;
            mag = sgn ? (32'd0 - v) : v;
        end
        else
        begin
            sgn = v[15];
            fb  = 12;
            mag = sgn ? ((32'h10000 - {16'd0, v[15:0]}) & 32'hFFFF) : {16'd0, v[15:0]};
            if (sgn && mag == 0)
                mag = 32'h8000;
        end
        if (mag == 0)
            return 32'd0;
        p = 0;
        for (int i = 0; i < 32; i++)
            if (mag[i])
                p = i;
        if (p <= 23)
            mant = {32'd0, mag} << (23 - p);
        else
        begin
            mant = round_shift({32'd0, mag}, p - 23);
            if (mant[24])
            begin
                mant = mant >> 1;
                p++;
            end
        end
        bexp = p + 127 - fb;
        return {sgn, bexp[7:0], mant[22:0]};
    endfunction

    assign pending = expected_words.size();

    always @(posedge clk or negedge rst_n)
    begin
        ffc_result_t exp_w;
        int          errs;
        errs = 0;
        if (!rst_n)
        begin
            cur_fmt    <= FMT_Q8_23;
            fail_count <= 0;
            expected_words.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_FORMAT)
                cur_fmt <= fmt_t'(pwdata[0]);
            if (s_tvalid && s_tready)
            begin
                if (op_t'(s_tuser) == OP_F2X)
                    exp_w = to_fixed(s_tdata, cur_fmt);
                else
                begin
                    exp_w.value    = to_float(s_tdata, cur_fmt);
                    exp_w.overflow = 1'b0;
                end
                expected_words.push_back(exp_w);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word value_out=%h", m_tdata);
                    errs++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (m_tdata !== exp_w.value)
                    begin
                        $error("value_out expected %h actual %h", exp_w.value, m_tdata);
                        errs++;
                    end
                    if (m_tuser !== exp_w.overflow)
                    begin
                        $error("overflow expected %b actual %b", exp_w.overflow, m_tuser);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the float/fixed converter with directed and random words in both
// fixed formats, with random stalls on both sides; the checker judges.
// ----------------------------------------------------------------------------
module tb;
    import ffc_pkg::*;

    localparam int CycleLimit = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          calm = 1'b0;   // no idling in the closing part

    always #1 clk = ~clk;

    float_fixed_converter i_dut (.*);

    ffc_checker i_checker (.*);

    // Watchdog: count every cycle and give up past the limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall in random bursts unless in the calm stretch.
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Write the format register through a setup and an access cycle.
    task automatic write_format(fmt_t f);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {REG_FORMAT, 2'b00};
        pwdata  <= {31'd0, f};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hand one word to the block, with an optional idle burst before it.
    task automatic send_word(op_t op, logic [31:0] v);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain: wait until the checker holds nothing, then idle before returning.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random float pattern, biased toward exponents near the fixed range.
    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[30:23] = 8'(120 + $urandom_range(0, 12));
            1: v[30:23] = 8'(100 + $urandom_range(0, 40));
            2: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: v[30:23] = 8'(127 + $urandom_range(0, 10) - 5);
        endcase
        return v;
    endfunction

    task automatic run_phase(fmt_t f, int count);
        write_format(f);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 1))
                send_word(OP_F2X, rand_float());
            else
                send_word(OP_X2F, $urandom);
        end
        drain();
    endtask

    initial
    begin
        logic [31:0] dir_f[] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                 32'hFF80_0000, 32'h7FC0_0001, 32'h0000_0001,
                                 32'h807F_FFFF, 32'h437F_FFFF, 32'h4380_0000,
                                 32'hC380_0000, 32'h4F00_0000, 32'h3F80_0000,
                                 32'h4100_0000, 32'hBF80_0000, 32'h3400_0000};
        logic [31:0] dir_x[] = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'hFFFF_8000, 32'h0000_8000, 32'h0000_7FFF,
                                 32'h0000_0001, 32'hFFFF_FFFF};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        // Directed: extremes and special cases in both formats.
        for (int f = 0; f < 2; f++)
        begin
            write_format(fmt_t'(f));
            foreach (dir_f[i])
                send_word(OP_F2X, dir_f[i]);
            foreach (dir_x[i])
                send_word(OP_X2F, dir_x[i]);
            drain();
        end
        run_phase(FMT_Q3_12, 250);
        run_phase(FMT_Q8_23, 250);
        run_phase(FMT_Q3_12, 150);
        calm = 1'b1;
        run_phase(FMT_Q8_23, 150);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/ffc_pkg.sv
hdl/ffc_f2x.sv
hdl/ffc_x2f.sv
hdl/float_fixed_converter.sv
hdl/ffc_checker.sv
bench/ffc_checker.sv
bench/tb.sv
